// ===== rtl/core/ptt_pkg.sv =====
// shared types, sizes and codes for the periodic timer table
package ptt_pkg;

   // table geometry
   localparam int MAX_SLOTS  = 16;
   localparam int TIME_BITS  = 32;
   localparam int SLOT_BITS  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int REM_W      = TIME_BITS + 2;
   localparam int ACC_W      = TIME_BITS + 3;
   localparam int SLOT_CMP_W = 8;
   localparam int MAX_FIRES  = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

   // fixed field widths of the ports
   localparam int FUNC_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int FIELD_W = 32;
   localparam int KIND_W  = 2;

   localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};
   // most negative remaining time, -2^(TIME_BITS+1)
   localparam logic signed [ACC_W-1:0] REM_MIN = {2'b11, {(TIME_BITS + 1){1'b0}}};

   // request operation codes
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADJUST = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd3;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TICK_SUB,
      ST_TICK_ADD,
      ST_TICK_END,
      ST_LEFT,
      ST_CMP_LEFT,
      ST_CMP_SHORT,
      ST_SEARCH
   } state_type;

   // write port of the slot memory
   typedef struct packed {
      logic                       per_we;
      logic                       rem_we;
      logic [SLOT_BITS-1:0]       addr;
      logic [TIME_BITS-1:0]       per;
      logic signed [REM_W-1:0]    rem;
   } mem_wr_type;

endpackage

// ===== rtl/core/ptt_alu.sv =====
// shared add/subtract unit with sign flag
module ptt_alu
   import ptt_pkg::*;
(
   input  alu_op_type               op,
   input  logic signed [ACC_W-1:0]  a,
   input  logic signed [ACC_W-1:0]  b,
   output logic signed [ACC_W-1:0]  sum,
   output logic                     neg
);

   // one wide adder, b inverted for subtract
   always_comb begin
      unique case (op)
         ALU_ADD: sum = a + b;
         ALU_SUB: sum = a - b;
      endcase
   end

   assign neg = sum[ACC_W-1];

endmodule

// ===== rtl/core/ptt_slot_mem.sv =====
// period and remaining-time storage, one write and one registered read per cycle
module ptt_slot_mem
   import ptt_pkg::*;
(
   input  logic                     clock,
   input  mem_wr_type               wr,
   input  logic [SLOT_BITS-1:0]     rd_addr,
   output logic [TIME_BITS-1:0]     rd_period,
   output logic signed [REM_W-1:0]  rd_rem
);

   logic [TIME_BITS-1:0]    period_mem [MAX_SLOTS];
   logic signed [REM_W-1:0] rem_mem    [MAX_SLOTS];

   // write port
   always_ff @(posedge clock) begin
      if (wr.per_we) begin
         period_mem[wr.addr] <= wr.per;
      end
      if (wr.rem_we) begin
         rem_mem[wr.addr] <= wr.rem;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_period <= period_mem[rd_addr];
      rd_rem    <= rem_mem[rd_addr];
   end

endmodule

// ===== rtl/core/periodic_timer_table_core.sv =====
// periodic timer table: sequencer, slot flags, shortest-period tracking and response register
// ticks run subtract and add states per slot; add and adjust run time-left and compares;
// removing the shortest slot searches anew; the rest end at decode; busy drops with the
// last response; a request is taken only when idle; a tick gives at most one fire per slot;
// responses cannot be stalled; synchronous reset clears slot flags and the shortest-slot
// record, stored periods and remaining times stay undefined until an add writes them
module periodic_timer_table_core
   import ptt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [FIELD_W-1:0]  req_period,
   input  logic [FIELD_W-1:0]  req_elapsed,
   output logic                rsp_strobe,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [SLOT_W-1:0]   rsp_fired_slot,
   output logic [FIELD_W-1:0]  rsp_count,
   output logic                rsp_last
);

   state_type                state_ff, state_in;
   logic [FUNC_W-1:0]        func_ff, func_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [TIME_BITS-1:0]     period_ff, period_in;
   logic [TIME_BITS-1:0]     elapsed_ff, elapsed_in;
   logic [SLOT_BITS-1:0]     idx_ff, idx_in;
   logic [FIRE_CNT_W-1:0]    fire_cnt_ff, fire_cnt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     reload_ff, reload_in;
   logic [MAX_SLOTS-1:0]     valid_ff, valid_in;
   logic [TIME_BITS-1:0]     short_per_ff, short_per_in;
   logic [SLOT_BITS-1:0]     short_slot_ff, short_slot_in;
   logic                     short_vld_ff, short_vld_in;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [KIND_W-1:0]        rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]        rsp_fired_slot_ff, rsp_fired_slot_in;
   logic [FIELD_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   alu_op_type               alu_op;
   logic signed [ACC_W-1:0]  alu_a, alu_b, alu_sum;
   logic                     alu_neg;

   mem_wr_type               mem_wr;
   logic [SLOT_BITS-1:0]     rd_addr;
   logic [TIME_BITS-1:0]     rd_period;
   logic signed [REM_W-1:0]  rd_rem;

   logic [SLOT_BITS-1:0]     slot_idx;
   logic                     slot_ok;
   logic                     slot_used;
   logic                     idx_last;
   logic                     acc_le_zero;
   logic                     slot_fires;

   // shared arithmetic unit
   ptt_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .sum (alu_sum),
      .neg (alu_neg)
   );

   // slot storage
   ptt_slot_mem u_mem (
      .clock     (clock),
      .wr        (mem_wr),
      .rd_addr   (rd_addr),
      .rd_period (rd_period),
      .rd_rem    (rd_rem)
   );

   // decode helpers
   assign slot_idx    = SLOT_BITS'(slot_ff);
   assign slot_ok     = SLOT_CMP_W'(slot_ff) < SLOT_CMP_W'(MAX_SLOTS);
   assign slot_used   = slot_ok && valid_ff[slot_idx];
   assign idx_last    = (idx_ff == SLOT_BITS'(MAX_SLOTS - 1));
   assign acc_le_zero = acc_ff[ACC_W-1] || (acc_ff == '0);
   assign slot_fires  = valid_ff[idx_ff] && acc_le_zero;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_func == FUNC_TICK) ? ST_TICK_SUB : ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (func_ff)
               FUNC_ADD:    state_in = (slot_ok && !slot_used) ? ST_LEFT : ST_IDLE;
               FUNC_ADJUST: state_in = slot_used ? ST_LEFT : ST_IDLE;
               FUNC_REMOVE: state_in = (slot_used && short_vld_ff && short_slot_ff == slot_idx)
                                       ? ST_SEARCH : ST_IDLE;
               FUNC_TICK:   state_in = ST_IDLE;
            endcase
         end
         ST_TICK_SUB:  state_in = ST_TICK_ADD;
         ST_TICK_ADD:  state_in = idx_last ? ST_TICK_END : ST_TICK_SUB;
         ST_TICK_END:  state_in = ST_IDLE;
         ST_LEFT:      state_in = ST_CMP_LEFT;
         ST_CMP_LEFT:  state_in = ST_CMP_SHORT;
         ST_CMP_SHORT: state_in = ST_IDLE;
         ST_SEARCH:    state_in = idx_last ? ST_IDLE : ST_SEARCH;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath control and response generation
   always_comb begin
      func_in           = func_ff;
      slot_in           = slot_ff;
      period_in         = period_ff;
      elapsed_in        = elapsed_ff;
      idx_in            = idx_ff;
      fire_cnt_in       = fire_cnt_ff;
      acc_in            = acc_ff;
      reload_in         = reload_ff;
      valid_in          = valid_ff;
      short_per_in      = short_per_ff;
      short_slot_in     = short_slot_ff;
      short_vld_in      = short_vld_ff;
      rsp_strobe_in     = 1'b0;
      rsp_kind_in       = KIND_NONE;
      rsp_fired_slot_in = '0;
      rsp_count_in      = '0;
      rsp_last_in       = 1'b0;
      alu_op            = ALU_SUB;
      alu_a             = '0;
      alu_b             = '0;
      rd_addr           = idx_ff;
      mem_wr            = '0;
      mem_wr.addr       = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in     = req_func;
               slot_in     = req_slot;
               period_in   = TIME_BITS'(req_period);
               elapsed_in  = TIME_BITS'(req_elapsed);
               idx_in      = '0;
               fire_cnt_in = '0;
               rd_addr     = '0;
            end
         end

         ST_DECODE: begin
            mem_wr.addr = slot_idx;
            mem_wr.per  = period_ff;
            mem_wr.rem  = REM_W'(period_ff);
            unique case (func_ff)
               FUNC_ADD: begin
                  if (slot_ok && !slot_used) begin
                     mem_wr.per_we      = 1'b1;
                     mem_wr.rem_we      = 1'b1;
                     valid_in[slot_idx] = 1'b1;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                  end
               end
               FUNC_ADJUST: begin
                  if (slot_used) begin
                     mem_wr.per_we = 1'b1;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  if (slot_used) begin
                     valid_in[slot_idx] = 1'b0;
                  end
                  // removing the shortest slot starts a search from slot zero
                  if (slot_used && short_vld_ff && short_slot_ff == slot_idx) begin
                     short_per_in  = TIME_MASK;
                     short_slot_in = '0;
                     short_vld_in  = 1'b0;
                     idx_in        = '0;
                     rd_addr       = '0;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                  end
               end
               FUNC_TICK: begin
                  rsp_strobe_in = 1'b1;
                  rsp_last_in   = 1'b1;
               end
            endcase
         end

         // time left on the hardware timer, held at zero
         ST_LEFT: begin
            alu_a  = {3'b000, short_per_ff};
            alu_b  = {3'b000, elapsed_ff};
            acc_in = alu_neg ? '0 : alu_sum;
         end

         // reprogram when the new period ends before the time left, or on an add with no shortest slot
         ST_CMP_LEFT: begin
            alu_a     = {3'b000, period_ff};
            alu_b     = acc_ff;
            reload_in = alu_neg || (func_ff == FUNC_ADD && !short_vld_ff);
         end

         // track the shortest period
         ST_CMP_SHORT: begin
            alu_a = {3'b000, period_ff};
            alu_b = {3'b000, short_per_ff};
            if (!short_vld_ff || alu_neg) begin
               short_per_in  = period_ff;
               short_slot_in = slot_idx;
               short_vld_in  = 1'b1;
            end
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_kind_in   = reload_ff ? KIND_RELOAD : KIND_NONE;
            rsp_count_in  = reload_ff ? FIELD_W'(period_ff) : '0;
         end

         // remaining minus elapsed, saturated at the negative limit
         ST_TICK_SUB: begin
            rd_addr = idx_ff;
            alu_a   = ACC_W'(rd_rem);
            alu_b   = {3'b000, elapsed_ff};
            acc_in  = (alu_sum < REM_MIN) ? REM_MIN : alu_sum;
         end

         // fire and reload, write back, fetch the next slot
         ST_TICK_ADD: begin
            alu_op      = ALU_ADD;
            alu_a       = acc_ff;
            alu_b       = {3'b000, rd_period};
            mem_wr.addr = idx_ff;
            mem_wr.rem  = slot_fires ? alu_sum[REM_W-1:0] : acc_ff[REM_W-1:0];
            if (valid_ff[idx_ff]) begin
               mem_wr.rem_we = 1'b1;
            end
            if (slot_fires && fire_cnt_ff < FIRE_CNT_W'(MAX_FIRES)) begin
               rsp_strobe_in     = 1'b1;
               rsp_kind_in       = KIND_FIRE;
               rsp_fired_slot_in = SLOT_W'(idx_ff);
               fire_cnt_in       = fire_cnt_ff + 1'b1;
            end
            if (!idx_last) begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end

         ST_TICK_END: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_kind_in   = short_vld_ff ? KIND_RELOAD : KIND_NONE;
            rsp_count_in  = short_vld_ff ? FIELD_W'(short_per_ff) : '0;
         end

         // one slot a cycle; ties go to the later slot
         ST_SEARCH: begin
            alu_a = {3'b000, short_per_ff};
            alu_b = {3'b000, rd_period};
            if (valid_ff[idx_ff] && !alu_neg) begin
               short_per_in  = rd_period;
               short_slot_in = idx_ff;
               short_vld_in  = 1'b1;
            end
            if (idx_last) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end

         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         short_per_ff  <= '0;
         short_slot_ff <= '0;
         short_vld_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         short_per_ff  <= short_per_in;
         short_slot_ff <= short_slot_in;
         short_vld_ff  <= short_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff           <= func_in;
      slot_ff           <= slot_in;
      period_ff         <= period_in;
      elapsed_ff        <= elapsed_in;
      idx_ff            <= idx_in;
      fire_cnt_ff       <= fire_cnt_in;
      acc_ff            <= acc_in;
      reload_ff         <= reload_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_fired_slot_ff <= rsp_fired_slot_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // ports
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_fired_slot = rsp_fired_slot_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

   // the final response of a request appears as the sequencer returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("last response while still busy");

   // an accepted request always occupies the sequencer
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not start the sequencer");

   // only fire responses come ahead of the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_kind == KIND_FIRE && busy)
      else $error("non-final response is not a fire");

   // the recorded shortest slot is always an occupied slot
   assert property (@(posedge clock) disable iff (reset)
      short_vld_ff |-> valid_ff[short_slot_ff])
      else $error("shortest slot is not occupied");

endmodule

// ===== tb/tb_periodic_timer_table_core.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the periodic timer table core
module tb_periodic_timer_table_core;
   import ptt_pkg::*;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] period;
      logic [FIELD_W-1:0] elapsed;
   } timer_request_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  fired_slot;
      logic [FIELD_W-1:0] count;
      logic               last;
   } timer_event_type;

   // floor of the signed remaining time
   localparam longint REM_FLOOR = -(longint'(1) <<< (TIME_BITS + 1));

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   logic [FUNC_W-1:0]  req_func    = '0;
   logic [SLOT_W-1:0]  req_slot    = '0;
   logic [FIELD_W-1:0] req_period  = '0;
   logic [FIELD_W-1:0] req_elapsed = '0;
   logic               rsp_strobe;
   logic [KIND_W-1:0]  rsp_kind;
   logic [SLOT_W-1:0]  rsp_fired_slot;
   logic [FIELD_W-1:0] rsp_count;
   logic               rsp_last;

   timer_request_type pending_requests [$];
   timer_event_type   expected_events [$];
   timer_request_type on_port;
   int                idle_pct = 12;
   int                mismatch_count = 0;

   // predicted table contents
   logic [TIME_BITS-1:0] tbl_period [MAX_SLOTS];
   longint               tbl_remaining [MAX_SLOTS];
   logic                 tbl_valid [MAX_SLOTS] = '{default: 1'b0};
   logic [TIME_BITS-1:0] short_period = '0;
   logic [SLOT_BITS-1:0] short_slot   = '0;
   logic                 short_valid  = 1'b0;

   // slot occupancy as seen by the request generator
   logic gen_valid [MAX_SLOTS] = '{default: 1'b0};

   periodic_timer_table_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_slot       (req_slot),
      .req_period     (req_period),
      .req_elapsed    (req_elapsed),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_count      (rsp_count),
      .rsp_last       (rsp_last)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ticks left on the hardware timer, held at zero instead of wrapping
   function automatic logic [TIME_BITS-1:0] time_to_expiry(input logic [TIME_BITS-1:0] elapsed);
      return (elapsed >= short_period) ? '0 : short_period - elapsed;
   endfunction

   // update the predicted table for one request and queue the events it causes
   function automatic void advance_timer_table(input timer_request_type rq);
      logic [KIND_W-1:0]  tail_kind;
      logic [FIELD_W-1:0] tail_count;
      longint             rem;
      int                 s;
      tail_kind  = KIND_NONE;
      tail_count = '0;
      s          = rq.slot;
      case (rq.func)
         FUNC_TICK: begin
            // walk valid slots in order, fire and reload those that ran out
            for (int i = 0; i < MAX_SLOTS; i++) begin
               if (tbl_valid[i]) begin
                  rem = tbl_remaining[i] - longint'({32'd0, rq.elapsed});
                  if (rem < REM_FLOOR) rem = REM_FLOOR;
                  if (rem <= 0) begin
                     expected_events.push_back('{kind: KIND_FIRE, fired_slot: SLOT_W'(i),
                                                 count: {FIELD_W{1'b0}}, last: 1'b0});
                     rem += longint'({32'd0, tbl_period[i]});
                  end
                  tbl_remaining[i] = rem;
               end
            end
            if (short_valid) begin
               tail_kind  = KIND_RELOAD;
               tail_count = short_period;
            end
         end
         FUNC_ADD: begin
            if (!tbl_valid[s]) begin
               tbl_period[s]    = rq.period;
               tbl_remaining[s] = longint'({32'd0, rq.period});
               tbl_valid[s]     = 1'b1;
               if (!short_valid || time_to_expiry(rq.elapsed) > rq.period) begin
                  tail_kind  = KIND_RELOAD;
                  tail_count = rq.period;
               end
               if (!short_valid || rq.period < short_period) begin
                  short_period = rq.period;
                  short_slot   = SLOT_BITS'(s);
                  short_valid  = 1'b1;
               end
            end
         end
         FUNC_ADJUST: begin
            // remaining time is kept, a longer period never triggers a search
            if (tbl_valid[s]) begin
               tbl_period[s] = rq.period;
               if (time_to_expiry(rq.elapsed) > rq.period) begin
                  tail_kind  = KIND_RELOAD;
                  tail_count = rq.period;
               end
               if (!short_valid || rq.period < short_period) begin
                  short_period = rq.period;
                  short_slot   = SLOT_BITS'(s);
                  short_valid  = 1'b1;
               end
            end
         end
         FUNC_REMOVE: begin
            if (tbl_valid[s]) begin
               tbl_valid[s] = 1'b0;
               // search again, a tie goes to the later slot
               if (short_valid && short_slot == SLOT_BITS'(s)) begin
                  short_period = TIME_MASK;
                  short_slot   = '0;
                  short_valid  = 1'b0;
                  for (int i = 0; i < MAX_SLOTS; i++) begin
                     if (tbl_valid[i] && tbl_period[i] <= short_period) begin
                        short_period = tbl_period[i];
                        short_slot   = SLOT_BITS'(i);
                        short_valid  = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      expected_events.push_back('{kind: tail_kind, fired_slot: {SLOT_W{1'b0}},
                                  count: tail_count, last: 1'b1});
   endfunction

   // queue one request; returns 0 when the core would ignore it
   function automatic bit queue_request(input logic [FUNC_W-1:0] func, input int slot,
                                        input logic [FIELD_W-1:0] period,
                                        input logic [FIELD_W-1:0] elapsed);
      bit effective;
      effective = 1'b1;
      case (func)
         FUNC_ADD: begin
            effective       = !gen_valid[slot];
            gen_valid[slot] = 1'b1;
         end
         FUNC_ADJUST: effective = gen_valid[slot];
         FUNC_REMOVE: begin
            effective       = gen_valid[slot];
            gen_valid[slot] = 1'b0;
         end
         default: ;
      endcase
      pending_requests.push_back('{func, SLOT_W'(slot), period, elapsed});
      return effective;
   endfunction

   // mostly a slot in the wanted state, sometimes any slot
   function automatic int pick_slot(input bit want_valid);
      int cands [$];
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (gen_valid[i] == want_valid) cands.push_back(i);
      end
      if (cands.size() == 0 || $urandom_range(99) < 15) return $urandom_range(MAX_SLOTS - 1);
      return cands[$urandom_range(cands.size() - 1)];
   endfunction

   // random requests until the given number of effective ones is queued
   task automatic queue_random_requests(input int target);
      int                 done_cnt;
      int                 pick;
      int                 slot;
      logic [FUNC_W-1:0]  func;
      logic [FIELD_W-1:0] period;
      logic [FIELD_W-1:0] elapsed;
      done_cnt = 0;
      while (done_cnt < target) begin
         pick = $urandom_range(99);
         if (pick < 35) func = FUNC_TICK;
         else if (pick < 60) func = FUNC_ADD;
         else if (pick < 78) func = FUNC_ADJUST;
         else func = FUNC_REMOVE;
         slot = pick_slot(func != FUNC_ADD);
         // short periods keep fires frequent
         pick = $urandom_range(99);
         if (pick < 70) period = $urandom_range(400, 1);
         else if (pick < 85) period = $urandom_range(5000, 401);
         else if (pick < 95) period = $urandom();
         else if (pick < 97) period = '0;
         else period = TIME_MASK;
         pick = $urandom_range(99);
         if (pick < 70) elapsed = $urandom_range(300);
         else if (pick < 85) elapsed = $urandom_range(2000);
         else if (pick < 95) elapsed = $urandom();
         else elapsed = TIME_MASK;
         if (queue_request(func, slot, period, elapsed)) done_cnt++;
      end
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || start || expected_events.size() != 0)
         @(negedge clock);
   endtask

   // request driver: holds a request until the core takes it
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            advance_timer_table(on_port);
         end
         if (!(start && busy)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
               on_port = pending_requests.pop_front();
               start       <= 1'b1;
               req_func    <= on_port.func;
               req_slot    <= on_port.slot;
               req_period  <= on_port.period;
               req_elapsed <= on_port.elapsed;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [FIELD_W-1:0] exp_val,
                                       input logic [FIELD_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   // response monitor: compare each strobed response with the oldest prediction
   always @(posedge clock) begin : response_check
      timer_event_type exp_ev;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_events.size() == 0) begin
            $error("unexpected response: kind %0h slot %0h count %0h last %0h",
                   rsp_kind, rsp_fired_slot, rsp_count, rsp_last);
            mismatch_count++;
         end else begin
            exp_ev = expected_events.pop_front();
            check_field("kind", FIELD_W'(exp_ev.kind), FIELD_W'(rsp_kind));
            check_field("fired_slot", FIELD_W'(exp_ev.fired_slot), FIELD_W'(rsp_fired_slot));
            check_field("count", exp_ev.count, rsp_count);
            check_field("last", FIELD_W'(exp_ev.last), FIELD_W'(rsp_last));
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: empty table, ignored requests, ties, re-search, zero period
      void'(queue_request(FUNC_TICK, 0, '0, '0));
      void'(queue_request(FUNC_REMOVE, 3, 32'd7, '0));
      void'(queue_request(FUNC_ADJUST, 5, 32'd9, '0));
      void'(queue_request(FUNC_ADD, 0, 32'd100, '0));
      void'(queue_request(FUNC_ADD, 0, 32'd5, '0));
      void'(queue_request(FUNC_ADD, 15, TIME_MASK, TIME_MASK));
      void'(queue_request(FUNC_ADD, 7, 32'd40, 32'd10));
      void'(queue_request(FUNC_ADD, 9, 32'd40, '0));
      void'(queue_request(FUNC_TICK, 0, '0, 32'd40));
      void'(queue_request(FUNC_ADJUST, 0, 32'd10, 32'd5));
      void'(queue_request(FUNC_ADJUST, 0, 32'd60, '0));
      void'(queue_request(FUNC_REMOVE, 0, '0, '0));
      void'(queue_request(FUNC_REMOVE, 9, '0, '0));
      void'(queue_request(FUNC_ADD, 2, '0, '0));
      // repeated full-scale ticks drive the zero-period slot to the floor
      void'(queue_request(FUNC_TICK, 0, '0, TIME_MASK));
      void'(queue_request(FUNC_TICK, 0, '0, TIME_MASK));
      void'(queue_request(FUNC_TICK, 0, '0, TIME_MASK));
      void'(queue_request(FUNC_ADJUST, 7, TIME_MASK, '0));
      void'(queue_request(FUNC_ADD, 10, 32'hAAAA_AAAA, 32'h5555_5555));
      void'(queue_request(FUNC_REMOVE, 2, '0, '0));
      void'(queue_request(FUNC_REMOVE, 7, '0, '0));
      void'(queue_request(FUNC_REMOVE, 10, '0, '0));
      void'(queue_request(FUNC_REMOVE, 15, '0, '0));
      void'(queue_request(FUNC_ADD, 4, 32'd1, '0));
      void'(queue_request(FUNC_TICK, 0, '0, 32'd1));
      queue_random_requests(120);
      wait_for_drain();
      // sender idles heavily
      idle_pct = 48;
      queue_random_requests(115);
      wait_for_drain();
      // back to back
      idle_pct = 0;
      queue_random_requests(115);
      wait_for_drain();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS periodic_timer_table_core");
      end else begin
         $display("FAIL periodic_timer_table_core");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAIL periodic_timer_table_core");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ptt_pkg.sv
rtl/core/ptt_alu.sv
rtl/core/ptt_slot_mem.sv
rtl/core/periodic_timer_table_core.sv
tb/tb_periodic_timer_table_core.sv
